// ===== src/wsdf_pkg.sv =====
// Package for the WebSocket frame deframer: opcode and frame type codes,
// the result item type and the opcode-to-type mapping.
// No dependencies.
package wsdf_pkg;

  // Opcodes from the first header byte
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Frame type codes reported on the result channel
  localparam logic [2:0] FT_TEXT   = 3'd0;
  localparam logic [2:0] FT_BINARY = 3'd1;
  localparam logic [2:0] FT_CLOSE  = 3'd2;
  localparam logic [2:0] FT_PING   = 3'd3;
  localparam logic [2:0] FT_PONG   = 3'd4;
  localparam logic [2:0] FT_NONE   = 3'd7;

  // Header length codes in the 7-bit length field
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Byte counts of the extended length and of the mask key
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // One result item
  typedef struct packed {
    logic       fin_bit;
    logic       has_data;
    logic [2:0] frame_type;
    logic [7:0] data_byte;
    logic       last_of_frame;
  } res_item_t;

  // Map an opcode to a reported frame type; FT_NONE means skip silently
  function automatic logic [2:0] type_of(input logic [3:0] op);
    logic [2:0] t;
    unique case (op)
      OP_TEXT:   t = FT_TEXT;
      OP_BINARY: t = FT_BINARY;
      OP_CLOSE:  t = FT_CLOSE;
      OP_PING:   t = FT_PING;
      OP_PONG:   t = FT_PONG;
      default:   t = FT_NONE;
    endcase
    return t;
  endfunction

endpackage

// ===== src/websocket_frame_deframer_core.sv =====
// WebSocket frame deframer: parses a received byte stream into frame events
// and unmasked payload bytes. Depends on wsdf_pkg.
//
// Usage:
//   Slave channel s_axis_*: one received stream byte per item in tdata.
//   Master channel m_axis_*: one result item per payload byte of a text,
//   binary, ping or pong frame, one event for an empty frame of those types,
//   and one close event at the end of a close frame. tlast marks the final
//   item of a frame; tuser carries frame type, has_data and the FIN flag.
//   Continuation and unknown opcodes are parsed and dropped without output.
// Output: a result enters the output register when the byte that causes it
//   is accepted, or the skid register while a result still waits there.
// Throughput: one byte per cycle while s_axis_tready_o is high; the header
//   parser, 64-bit payload decrement and unmask XOR settle in the accepting cycle.
// Stall: results sit in an output register backed by one skid register, so
//   a byte is still taken while a finished result waits; s_axis_tready_o
//   falls only once both hold results, and rises again when the receiver
//   takes one.
// Reset: rst_ni clears the parser to wait for a first header byte and empties
//   the output and skid registers.
module websocket_frame_deframer_core
  import wsdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic       m_axis_tlast_o,   // last_of_frame
  output logic [4:0] m_axis_tuser_o    // [2:0] frame_type, [3] has_data, [4] fin_bit
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        fin_q, fin_d;
  logic        mask_q, mask_d;
  logic [3:0]  hdr_left_q, hdr_left_d;
  logic [63:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  mpos_q, mpos_d;

  logic        out_vld_q, skid_vld_q;
  res_item_t   out_q, skid_q;

  logic        s_acc, out_pop;
  logic        r_vld;
  res_item_t   r_item;
  logic        len_done, hdr_done;
  logic [2:0]  cur_type;
  logic [63:0] remain_dec;
  logic [7:0]  key_byte;
  logic        pay_last;

  assign s_axis_tready_o = ~skid_vld_q;
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;
  assign out_pop         = out_vld_q & m_axis_tready_i;

  assign cur_type   = type_of(opcode_q);
  assign remain_dec = remain_q - 64'd1;
  assign pay_last   = (remain_dec == 64'd0);

  // Pick the key byte for this payload byte, first key byte at position 0
  always_comb begin
    unique case (mpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Parse one byte: next parser state and the result it causes
  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    fin_d      = fin_q;
    mask_d     = mask_q;
    hdr_left_d = hdr_left_q;
    remain_d   = remain_q;
    key_d      = key_q;
    mpos_d     = mpos_q;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    r_vld      = 1'b0;
    r_item     = '{fin_bit: fin_q, has_data: 1'b0, frame_type: FT_TEXT,
                   data_byte: 8'h00, last_of_frame: 1'b0};

    unique case (phase_q)
      PH_HDR1: begin
        mask_d   = s_axis_tdata_i[7];
        remain_d = 64'd0;
        if (s_axis_tdata_i[6:0] < LEN_EXT16) begin
          remain_d = {57'd0, s_axis_tdata_i[6:0]};
          len_done = 1'b1;
        end else begin
          hdr_left_d = (s_axis_tdata_i[6:0] == LEN_EXT64) ? EXT64_BYTES : EXT16_BYTES;
          phase_d    = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        remain_d   = {remain_q[55:0], s_axis_tdata_i};
        hdr_left_d = hdr_left_q - 4'd1;
        len_done   = (hdr_left_d == 4'd0);
      end
      PH_KEY: begin
        key_d      = {key_q[23:0], s_axis_tdata_i};
        hdr_left_d = hdr_left_q - 4'd1;
        hdr_done   = (hdr_left_d == 4'd0);
      end
      PH_PAYLOAD: begin
        remain_d = remain_dec;
        mpos_d   = mpos_q + 2'd1;
        if (pay_last) begin
          phase_d = PH_HDR0;
        end
        if (cur_type == FT_CLOSE) begin
          // Skip close payload, report once at its end
          r_vld                = pay_last;
          r_item.frame_type    = FT_CLOSE;
          r_item.last_of_frame = 1'b1;
        end else if (cur_type != FT_NONE) begin
          r_vld                = 1'b1;
          r_item.frame_type    = cur_type;
          r_item.has_data      = 1'b1;
          r_item.data_byte     = s_axis_tdata_i ^ (mask_q ? key_byte : 8'h00);
          r_item.last_of_frame = pay_last;
        end
      end
      default: begin
        // First header byte, also for unused phase codes
        fin_d    = s_axis_tdata_i[7];
        opcode_d = s_axis_tdata_i[3:0];
        phase_d  = PH_HDR1;
      end
    endcase

    // Length complete: collect the key or close the header
    if (len_done) begin
      if (mask_d) begin
        hdr_left_d = KEY_BYTES;
        key_d      = 32'd0;
        phase_d    = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: enter payload or finish an empty frame
    if (hdr_done) begin
      mpos_d = 2'd0;
      if (remain_d != 64'd0) begin
        phase_d = PH_PAYLOAD;
      end else begin
        phase_d = PH_HDR0;
        if (cur_type != FT_NONE) begin
          r_vld                = 1'b1;
          r_item.frame_type    = cur_type;
          r_item.last_of_frame = 1'b1;
        end
      end
    end
  end

  // Hold parser state, advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      opcode_q   <= 4'd0;
      fin_q      <= 1'b0;
      mask_q     <= 1'b0;
      hdr_left_q <= 4'd0;
      remain_q   <= 64'd0;
      key_q      <= 32'd0;
      mpos_q     <= 2'd0;
    end else if (s_acc) begin
      phase_q    <= phase_d;
      opcode_q   <= opcode_d;
      fin_q      <= fin_d;
      mask_q     <= mask_d;
      hdr_left_q <= hdr_left_d;
      remain_q   <= remain_d;
      key_q      <= key_d;
      mpos_q     <= mpos_d;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_pop) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_pop) begin
      out_vld_q <= s_acc & r_vld;
    end else if (s_acc && r_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Payload of the output and skid registers
  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_pop) begin
      if (s_acc && r_vld) begin
        out_q <= r_item;
      end
    end else if (s_acc && r_vld) begin
      skid_q <= r_item;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q.data_byte;
  assign m_axis_tlast_o  = out_q.last_of_frame;
  assign m_axis_tuser_o  = {out_q.fin_bit, out_q.has_data, out_q.frame_type};

endmodule

// ===== src/wsdf_checker.sv =====
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on wsdf_pkg and websocket_frame_deframer_core.
module wsdf_checker
  import wsdf_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic [4:0] m_axis_tuser_o
);

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("stalled result item changed");

  // An item without data is always a frame's final event with zero data
  a_nodata_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[3] |-> m_axis_tlast_o && (m_axis_tdata_o == 8'h00))
    else $error("event without data is not a zeroed final item");

  // Close frames never carry data
  a_close_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[2:0] == FT_CLOSE) |-> !m_axis_tuser_o[3])
    else $error("close event carries data");

  // Only known frame types are reported
  a_type_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[2:0] == FT_TEXT) || (m_axis_tuser_o[2:0] == FT_BINARY)
      || (m_axis_tuser_o[2:0] == FT_CLOSE) || (m_axis_tuser_o[2:0] == FT_PING)
      || (m_axis_tuser_o[2:0] == FT_PONG))
    else $error("unknown frame type reported");

endmodule

bind websocket_frame_deframer_core wsdf_checker u_wsdf_checker (.*);
